FILE: rtl/core/mqbrb_pkg.sv
// Package for the multi-queue byte ring buffer: sizes, command codes,
// word structs and the memory request struct shared by all core modules.
// No dependencies.
package mqbrb_pkg;

  localparam int NUM_QUEUES  = 4;
  localparam int QUEUE_DEPTH = 64;

  localparam int PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QSEL_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int STORE_SIZE = NUM_QUEUES * QUEUE_DEPTH;
  localparam int STORE_AW   = $clog2(STORE_SIZE);

  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [QSEL_W-1:0]   qsel_t;
  typedef logic [STORE_AW-1:0] store_addr_t;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_STATUS  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] queue_index;
    logic [7:0] byte_in;
    logic       transmitter_idle;
  } in_word_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       stored;
    logic       sent_direct;
    logic       queue_empty;
    logic       queue_full;
  } out_word_t;

  // Per-item status flags, everything of the result but the byte itself.
  typedef struct packed {
    logic byte_valid;
    logic stored;
    logic sent_direct;
    logic queue_empty;
    logic queue_full;
  } res_flags_t;

  // One write port and one read port into the byte store.
  typedef struct packed {
    logic        we;
    store_addr_t waddr;
    logic [7:0]  wdata;
    logic        re;
    store_addr_t raddr;
  } mem_req_t;

endpackage

FILE: rtl/core/mqbrb_store.sv
// Byte store of the ring buffer bank: one write and one registered read per cycle.
// Depends on mqbrb_pkg for the request struct and store size.
module mqbrb_store
  import mqbrb_pkg::*;
(
  input  logic       clk,
  input  mem_req_t   mem_req,
  output logic [7:0] rd_data_r
);

  logic [7:0] mem [STORE_SIZE];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // Hold the read data until the next read so a stalled result keeps its byte.
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

endmodule

FILE: rtl/core/mqbrb_ctrl.sv
// Pointer bank and per-item decision logic of the ring buffer bank.
// Depends on mqbrb_pkg; drives the byte store request and the result flags.
module mqbrb_ctrl
  import mqbrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  in_word_t   item,
  input  logic [1:0] bypass_queue,
  output mem_req_t   mem_req,
  output res_flags_t res
);

  ptr_t wp_r [NUM_QUEUES];
  ptr_t rp_r [NUM_QUEUES];

  logic        in_range;
  qsel_t       qsel;
  ptr_t        wp;
  ptr_t        rp;
  ptr_t        nwp;
  ptr_t        nrp;
  logic        empty;
  logic        full;
  logic        do_store;
  logic        do_direct;
  logic        do_deq;
  store_addr_t base;

  always_comb begin
    in_range  = int'(item.queue_index) < NUM_QUEUES;
    qsel      = QSEL_W'(item.queue_index);
    wp        = wp_r[qsel];
    rp        = rp_r[qsel];
    nwp       = wp + ptr_t'(1);
    nrp       = rp + ptr_t'(1);
    empty     = (wp == rp);
    full      = (nwp == rp);
    base      = STORE_AW'(int'(qsel) * QUEUE_DEPTH);
    do_store  = 1'b0;
    do_direct = 1'b0;
    do_deq    = 1'b0;
    if (in_range) begin
      case (item.command)
        CMD_ENQUEUE: begin
          if (!full) begin
            if ((item.queue_index == bypass_queue) && item.transmitter_idle) begin
              do_direct = 1'b1;
            end else begin
              do_store = 1'b1;
            end
          end
        end
        CMD_DEQUEUE: begin
          do_deq = !empty;
        end
        default: begin
          // status query and the unused code change nothing
        end
      endcase
    end
  end

  always_comb begin
    res.byte_valid  = do_deq;
    res.stored      = do_store;
    res.sent_direct = do_direct;
    res.queue_empty = in_range ? empty : 1'b1;
    res.queue_full  = in_range ? full : 1'b0;
  end

  always_comb begin
    mem_req.we    = fire && do_store;
    mem_req.waddr = base + STORE_AW'(nwp);
    mem_req.wdata = item.byte_in;
    mem_req.re    = fire && do_deq;
    mem_req.raddr = base + STORE_AW'(nrp);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        wp_r[i] <= '0;
        rp_r[i] <= '0;
      end
    end else if (fire) begin
      if (do_store) begin
        wp_r[qsel] <= nwp;
      end
      if (do_deq) begin
        rp_r[qsel] <= nrp;
      end
    end
  end

  a_no_rw_same_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.we && mem_req.re))
    else $error("store written and read for one item");

  a_one_enq_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.stored && res.sent_direct))
    else $error("byte both stored and sent direct");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !(res.queue_full && res.queue_empty))
    else $error("queue reported full and empty at once");

  a_store_leaves_data: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |=> (wp_r[$past(qsel)] != rp_r[$past(qsel)]))
    else $error("queue empty right after a byte was stored");

endmodule

FILE: rtl/core/multi_queue_byte_ring_buffer_core.sv
// Bank of byte ring buffers with a bypass queue for an idle transmitter.
// Path: an accepted word is registered in the input stage, then its flags in the result stage.
// Throughput: one word per cycle unless out_stall holds the stages; at most one store access per word.
// Reset (synchronous, rst_n low): clear pointers, bypass_queue and both valid stages.
// The byte store is not cleared; the pointer discipline never reads an unwritten entry.
// Depends on mqbrb_pkg, mqbrb_ctrl and mqbrb_store.
module multi_queue_byte_ring_buffer_core
  import mqbrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_bypass_queue
);

  // Configuration register: always ready; to be written only while the bank is idle, not enforced.
  logic [1:0] bypass_r;

  // Input stage: the word being worked on.
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  in_word_t   s1_item_r;

  // Result stage: flags registered here, the byte comes from the store read register.
  logic       out_valid_r;
  logic       out_valid_nxt;
  res_flags_t out_flags_r;

  logic       s1_adv;
  logic       in_fire;
  logic       fire;
  mem_req_t   mem_req;
  res_flags_t res;
  logic [7:0] rd_data;

  assign cfg_ready = 1'b1;

  // Advance the input stage whenever the result stage is empty or drains.
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;
  assign fire     = s1_valid_r && s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bypass_r <= cfg_bypass_queue;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture on accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_word;
    end
    if (fire) begin
      out_flags_r <= res;
    end
  end

  mqbrb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .item         (s1_item_r),
    .bypass_queue (bypass_r),
    .mem_req      (mem_req),
    .res          (res)
  );

  mqbrb_store u_store (
    .clk       (clk),
    .mem_req   (mem_req),
    .rd_data_r (rd_data)
  );

  // Drop the stale read register onto zero when no byte was taken.
  always_comb begin
    out_word.byte_out    = out_flags_r.byte_valid ? rd_data : 8'd0;
    out_word.byte_valid  = out_flags_r.byte_valid;
    out_word.stored      = out_flags_r.stored;
    out_word.sent_direct = out_flags_r.sent_direct;
    out_word.queue_empty = out_flags_r.queue_empty;
    out_word.queue_full  = out_flags_r.queue_full;
  end

  assign out_valid = out_valid_r;

endmodule

FILE: test/multi_queue_byte_ring_buffer_core_tb.sv
// Testbench for multi_queue_byte_ring_buffer_core: drives command words, mirrors the
// four byte rings and the bypass register, and checks every result word field by field.
// Depends on mqbrb_pkg and the core RTL only.
`timescale 1ns / 1ps

module multi_queue_byte_ring_buffer_core_tb;
  import mqbrb_pkg::*;

  // Command code 3 is unused; the block must treat it as a status query.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Cycles without any handshake before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;
  // Idle margin after draining, before config writes and the end.
  localparam int SETTLE_CYCLES = 6;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_word_t   in_word = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_word;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_bypass_queue = '0;

  multi_queue_byte_ring_buffer_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_word          (in_word),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word         (out_word),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_bypass_queue (cfg_bypass_queue)
  );

  always #5 clk = ~clk;

  // Mirror of the ring bank: pointers, byte store and bypass selection.
  ptr_t       wr_ptr [NUM_QUEUES];
  ptr_t       rd_ptr [NUM_QUEUES];
  logic [7:0] ring_mem [STORE_SIZE];
  qsel_t      bypass_sel;

  in_word_t   queued_cmds[$];        // words waiting for the driver
  out_word_t  predicted_replies[$];  // one reply per accepted word, oldest first
  out_word_t  want_word;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // Apply one command word to the mirror and return the reply it must produce.
  // Flags report the queue as it stood before the word.
  function automatic out_word_t ring_bank_step(in_word_t w);
    out_word_t   r;
    ptr_t        wp, rp, nwp, nrp;
    int          q;
    qsel_t       qs;
    store_addr_t base;
    r = '0;
    r.queue_empty = 1'b1;
    q  = int'(w.queue_index);
    qs = w.queue_index;
    if (q < NUM_QUEUES) begin
      wp   = wr_ptr[qs];
      rp   = rd_ptr[qs];
      nwp  = wp + ptr_t'(1);
      base = store_addr_t'(q * QUEUE_DEPTH);
      r.queue_empty = (wp == rp);
      r.queue_full  = (nwp == rp);
      case (w.command)
        CMD_ENQUEUE: begin
          // Drop on full, bypass queue included.
          if (!r.queue_full) begin
            if (w.queue_index == bypass_sel && w.transmitter_idle) begin
              r.sent_direct = 1'b1;
            end else begin
              ring_mem[base + store_addr_t'(nwp)] = w.byte_in;
              wr_ptr[qs] = nwp;
              r.stored = 1'b1;
            end
          end
        end
        CMD_DEQUEUE: begin
          if (!r.queue_empty) begin
            nrp = rp + ptr_t'(1);
            rd_ptr[qs] = nrp;
            r.byte_out = ring_mem[base + store_addr_t'(nrp)];
            r.byte_valid = 1'b1;
          end
        end
        default: ;  // status query and the unused code change nothing
      endcase
    end
    return r;
  endfunction

  function automatic in_word_t make_word(logic [1:0] cmd, int q, int b, bit idle);
    in_word_t w;
    w.command          = cmd;
    w.queue_index      = q[1:0];
    w.byte_in          = b[7:0];
    w.transmitter_idle = idle;
    return w;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: predict on acceptance, then present the next word or idle.
  // A word held under stall keeps valid and payload steady.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_replies.push_back(ring_bank_step(in_word));
      end
      if (!in_valid || !in_stall) begin
        if (queued_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_word  <= queued_cmds.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted reply against the oldest prediction,
  // then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          $display("%0t ns: unexpected result word %h", $time, out_word);
          mismatches++;
        end else begin
          want_word = predicted_replies.pop_front();
          check_field("byte_out", want_word.byte_out, out_word.byte_out);
          check_field("byte_valid", 8'(want_word.byte_valid), 8'(out_word.byte_valid));
          check_field("stored", 8'(want_word.stored), 8'(out_word.stored));
          check_field("sent_direct", 8'(want_word.sent_direct),
                      8'(out_word.sent_direct));
          check_field("queue_empty", 8'(want_word.queue_empty),
                      8'(out_word.queue_empty));
          check_field("queue_full", 8'(want_word.queue_full), 8'(out_word.queue_full));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: count cycles in which no channel moves a word.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Hold the sender until every queued word is accepted and every reply has come back,
  // then let the pipeline settle.
  task automatic drain_all();
    while (queued_cmds.size() != 0 || in_valid || predicted_replies.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the bypass register; only called with the block idle.
  task automatic write_bypass(logic [1:0] sel);
    @(posedge clk);
    cfg_valid        <= 1'b1;
    cfg_bypass_queue <= sel;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    bypass_sel = sel;
  endtask

  // Queue random traffic: mostly fill and drain bursts on one queue, so that rings
  // wrap and reach both full and empty, plus short runs of arbitrary words.
  task automatic add_traffic(int count);
    int added, q, len, kind;
    bit idle;
    added = 0;
    while (added < count) begin
      q    = $urandom_range(NUM_QUEUES - 1);
      kind = $urandom_range(9);
      if (kind <= 3) begin
        len  = $urandom_range(70, 1);
        if (len > count - added) len = count - added;
        for (int i = 0; i < len; i++) begin
          idle = ($urandom_range(3) == 0);
          queued_cmds.push_back(make_word(CMD_ENQUEUE, q, $urandom_range(255), idle));
        end
      end else if (kind <= 6) begin
        len = $urandom_range(70, 1);
        if (len > count - added) len = count - added;
        for (int i = 0; i < len; i++)
          queued_cmds.push_back(make_word(CMD_DEQUEUE, q, $urandom_range(255),
                                          1'($urandom_range(1))));
      end else begin
        len = $urandom_range(8, 1);
        if (len > count - added) len = count - added;
        for (int i = 0; i < len; i++)
          queued_cmds.push_back(make_word(2'($urandom_range(3)),
                                          $urandom_range(NUM_QUEUES - 1),
                                          $urandom_range(255), 1'($urandom_range(1))));
      end
      added += len;
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_QUEUES; i++) begin
      wr_ptr[i] = '0;
      rd_ptr[i] = '0;
    end
    bypass_sel = '0;

    // Hold reset, then release it for good.
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, bypass queue at its reset value of 0.
    queued_cmds.push_back(make_word(CMD_STATUS, 0, 8'h00, 1'b0));   // fresh queue is empty
    queued_cmds.push_back(make_word(CMD_DEQUEUE, 0, 8'hFF, 1'b1));  // dequeue from empty
    queued_cmds.push_back(make_word(CMD_ENQUEUE, 0, 8'h00, 1'b1));  // bypass to idle tx
    queued_cmds.push_back(make_word(CMD_ENQUEUE, 0, 8'hFF, 1'b0));  // bypass queue, tx busy
    queued_cmds.push_back(make_word(CMD_ENQUEUE, 1, 8'hFF, 1'b1));  // idle tx, other queue
    queued_cmds.push_back(make_word(CMD_ENQUEUE, 1, 8'h00, 1'b0));
    queued_cmds.push_back(make_word(CMD_ENQUEUE, 2, 8'hA5, 1'b1));
    queued_cmds.push_back(make_word(CMD_ENQUEUE, 3, 8'h5A, 1'b1));
    queued_cmds.push_back(make_word(CMD_STATUS, 1, 8'h33, 1'b1));
    queued_cmds.push_back(make_word(CMD_UNUSED, 1, 8'hCC, 1'b1));   // unused code
    queued_cmds.push_back(make_word(CMD_DEQUEUE, 0, 8'h00, 1'b0));
    queued_cmds.push_back(make_word(CMD_DEQUEUE, 0, 8'h00, 1'b0));  // empty again
    queued_cmds.push_back(make_word(CMD_DEQUEUE, 1, 8'h00, 1'b0));
    queued_cmds.push_back(make_word(CMD_DEQUEUE, 1, 8'h00, 1'b0));
    queued_cmds.push_back(make_word(CMD_DEQUEUE, 2, 8'h00, 1'b1));
    queued_cmds.push_back(make_word(CMD_DEQUEUE, 3, 8'h00, 1'b1));
    queued_cmds.push_back(make_word(CMD_UNUSED, 3, 8'hFF, 1'b0));
    queued_cmds.push_back(make_word(CMD_STATUS, 3, 8'h00, 1'b0));
    drain_all();

    // No idling, bypass on the top queue.
    write_bypass(2'd3);
    add_traffic(360);
    drain_all();

    // Sender idle half the time.
    send_idle_pct = 50;
    write_bypass(2'd1);
    add_traffic(360);
    drain_all();

    // Receiver stalling half the time.
    send_idle_pct  = 0;
    recv_stall_pct = 50;
    write_bypass(2'd2);
    add_traffic(360);
    drain_all();

    // Both sides idling lightly, bypass back on queue 0.
    send_idle_pct  = 9;
    recv_stall_pct = 9;
    write_bypass(2'd0);
    add_traffic(370);
    drain_all();

    if (mismatches == 0 && predicted_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: multi_queue_byte_ring_buffer_core.f
rtl/core/mqbrb_pkg.sv
rtl/core/mqbrb_store.sv
rtl/core/mqbrb_ctrl.sv
rtl/core/multi_queue_byte_ring_buffer_core.sv
test/multi_queue_byte_ring_buffer_core_tb.sv
